[rtl/tms_pkg.sv]
// Package: shared types, constants and action/status codes of the subdivider.
`timescale 1ns / 1ps
package tms_pkg;
  localparam int VertexDepth   = 4096;
  localparam int TriangleDepth = 8192;
  localparam int VW = $clog2(VertexDepth);    // vertex index bits
  localparam int TW = $clog2(TriangleDepth);  // triangle slot bits

  typedef enum logic [1:0] {
    ACT_VERTEX = 2'd0, ACT_TRIANGLE = 2'd1, ACT_SUBDIV = 2'd2, ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_VFULL = 2'd1, ST_TFULL = 2'd2, ST_BADIDX = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [11:0]        corner_a;
    logic [11:0]        corner_b;
    logic [11:0]        corner_c;
    logic [12:0]        face_index;
  } in_beat_t;

  typedef struct packed {
    logic [12:0] result_index;
    logic [11:0] face_a;
    logic [11:0] face_b;
    logic [11:0] face_c;
    logic [1:0]  status;
    logic        last;
  } out_beat_t;

  localparam int QDEPTH = 2;
endpackage

[rtl/tms_front.sv]
// Front end: two-entry command queue between the input port and the engine.
`timescale 1ns / 1ps
module tms_front import tms_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_beat_t in_data,
  output logic     full,
  output logic     cmd_valid,
  output in_beat_t cmd,
  input  logic     cmd_take
);
  in_beat_t    q_r [QDEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        wr, rd;

  assign full      = (cnt_r == 2'(QDEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign wr = push && !full;
  assign rd = cmd_take && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= in_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

[rtl/tms_engine.sv]
// Back end: stores, midpoint search sequencer and result queue.
`timescale 1ns / 1ps
module tms_engine import tms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  in_beat_t  cmd,
  output logic      cmd_take,
  output logic      empty,
  output out_beat_t out_data,
  input  logic      pop
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_TRD  = 10'b0000000010, S_TWT  = 10'b0000000100,
    S_VRD  = 10'b0000001000, S_VWT  = 10'b0000010000, S_MID  = 10'b0000100000,
    S_SRD  = 10'b0001000000, S_SCMP = 10'b0010000000, S_MOVE = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

  logic [95:0]   vmem [VertexDepth];
  logic [35:0]   tmem [TriangleDepth];
  logic [95:0]   vrd_r;
  logic [35:0]   trd_r;
  logic [VW-1:0] vaddr;
  logic [TW-1:0] taddr;
  logic          vwe, twe;
  logic [95:0]   vwd;
  logic [35:0]   twd;

  state_t      st_r, st_nxt;
  logic [VW:0] vcnt_r, vcnt_nxt;
  logic [TW:0] tcnt_r, tcnt_nxt;
  in_beat_t    c_r, c_nxt;
  logic [11:0] cor_r [3], cor_nxt [3];
  logic [95:0] pv_r [3], pv_nxt [3];   // corner points then midpoints
  logic [11:0] mid_r [3], mid_nxt [3];
  logic [1:0]  idx_r, idx_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [VW:0] j_r, j_nxt;
  logic [35:0] moved_r, moved_nxt;
  logic [2:0]  emit_r, emit_nxt;

  // output queue
  out_beat_t   oq_r [4];
  logic [1:0]  owp_r, orp_r;
  logic [2:0]  ocnt_r;
  logic        opush;
  out_beat_t   od;

  // vertex memory port
  always_ff @(posedge clk) begin
    if (vwe) vmem[vaddr] <= vwd;
    vrd_r <= vmem[vaddr];
  end
  // triangle memory port
  always_ff @(posedge clk) begin
    if (twe) tmem[taddr] <= twd;
    trd_r <= tmem[taddr];
  end

  function automatic logic [31:0] half(input logic [31:0] p, input logic [31:0] q);
    logic [32:0] s;
    s = {p[31], p} + {q[31], q};
    return s[32:1];
  endfunction

  function automatic logic [95:0] midp(input logic [95:0] p, input logic [95:0] q);
    return {half(p[95:64], q[95:64]), half(p[63:32], q[63:32]), half(p[31:0], q[31:0])};
  endfunction

  function automatic out_beat_t mk(input logic [12:0] ri, input logic [11:0] a,
    input logic [11:0] b, input logic [11:0] c, input status_t s, input logic l);
    out_beat_t o;
    o.result_index = ri; o.face_a = a; o.face_b = b; o.face_c = c;
    o.status = s; o.last = l;
    return o;
  endfunction

  assign empty    = (ocnt_r == 3'd0);
  assign out_data = oq_r[orp_r];

  // sequencer
  always_comb begin
    logic [VW:0] newi;
    logic [TW:0] slot;
    logic        hit;
    logic [11:0] cc [3];
    st_nxt = st_r; vcnt_nxt = vcnt_r; tcnt_nxt = tcnt_r; c_nxt = c_r;
    cor_nxt = cor_r; pv_nxt = pv_r; mid_nxt = mid_r; idx_nxt = idx_r;
    pend_nxt = pend_r; j_nxt = j_r; moved_nxt = moved_r;
    emit_nxt = emit_r;
    cmd_take = 1'b0; opush = 1'b0; od = '0;
    vaddr = '0; taddr = '0; vwe = 1'b0; twe = 1'b0; vwd = '0; twd = '0;
    newi = '0; slot = '0; hit = 1'b0;
    for (int i = 0; i < 3; i++) cc[i] = cor_r[i];
    unique case (st_r)
      S_IDLE: begin
        // output queue needs room for four beats before a command starts
        if (cmd_valid && ocnt_r == 3'd0) begin
          cmd_take = 1'b1;
          c_nxt = cmd;
          unique case (action_t'(cmd.action))
            ACT_VERTEX: begin
              opush = 1'b1;
              if (vcnt_r >= (VW+1)'(VertexDepth)) od = mk('0, '0, '0, '0, ST_VFULL, 1'b1);
              else begin
                vaddr = vcnt_r[VW-1:0]; vwe = 1'b1;
                vwd = {cmd.coord_x, cmd.coord_y, cmd.coord_z};
                od = mk(13'(vcnt_r), '0, '0, '0, ST_OK, 1'b1);
                vcnt_nxt = vcnt_r + 1'b1;
              end
            end
            ACT_TRIANGLE: begin
              opush = 1'b1;
              if ((VW+1)'(cmd.corner_a) >= vcnt_r || (VW+1)'(cmd.corner_b) >= vcnt_r ||
                  (VW+1)'(cmd.corner_c) >= vcnt_r)
                od = mk('0, '0, '0, '0, ST_BADIDX, 1'b1);
              else if (tcnt_r >= (TW+1)'(TriangleDepth))
                od = mk('0, '0, '0, '0, ST_TFULL, 1'b1);
              else begin
                taddr = tcnt_r[TW-1:0]; twe = 1'b1;
                twd = {cmd.corner_a, cmd.corner_b, cmd.corner_c};
                od = mk(13'(tcnt_r), cmd.corner_a, cmd.corner_b, cmd.corner_c,
                        ST_OK, 1'b1);
                tcnt_nxt = tcnt_r + 1'b1;
              end
            end
            ACT_CLEAR: begin
              opush = 1'b1; od = mk('0, '0, '0, '0, ST_OK, 1'b1);
              vcnt_nxt = '0; tcnt_nxt = '0;
            end
            default: begin
              if ((TW+1)'(cmd.face_index) >= tcnt_r) begin
                opush = 1'b1; od = mk('0, '0, '0, '0, ST_BADIDX, 1'b1);
              end else if (tcnt_r + (TW+1)'(3) > (TW+1)'(TriangleDepth)) begin
                opush = 1'b1; od = mk('0, '0, '0, '0, ST_TFULL, 1'b1);
              end else begin
                taddr = cmd.face_index[TW-1:0];
                st_nxt = S_TRD;
              end
            end
          endcase
        end
      end
      S_TRD: begin
        // selected triangle has arrived; fetch the last one
        cor_nxt[0] = trd_r[35:24]; cor_nxt[1] = trd_r[23:12]; cor_nxt[2] = trd_r[11:0];
        for (int i = 0; i < 3; i++)
          if ((VW+1)'(cor_nxt[i]) >= (VW+1)'(VertexDepth)) cor_nxt[i] = '0;
        taddr = TW'(tcnt_r - 1'b1);
        st_nxt = S_TWT;
      end
      S_TWT: begin
        // last triangle, kept to refill the removed slot
        moved_nxt = trd_r;
        idx_nxt = 2'd0;
        st_nxt = S_VRD;
      end
      S_VRD: begin
        // corner reads pipelined: each corner's data is captured the cycle after its address
        vaddr = cc[idx_r][VW-1:0];
        if (idx_r != 2'd0) pv_nxt[idx_r - 2'd1] = vrd_r;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == 2'd2) st_nxt = S_VWT;
      end
      S_VWT: begin
        pv_nxt[2] = vrd_r;
        st_nxt = S_MID;
      end
      S_MID: begin
        pv_nxt[0] = midp(pv_r[0], pv_r[1]);
        pv_nxt[1] = midp(pv_r[1], pv_r[2]);
        pv_nxt[2] = midp(pv_r[2], pv_r[0]);
        idx_nxt = 2'd0; pend_nxt = 2'd0; j_nxt = '0;
        st_nxt = S_SRD;
      end
      S_SRD: begin
        // linear search: each stored vertex is read in S_SRD and compared in S_SCMP
        if (j_r < vcnt_r) begin
          vaddr = j_r[VW-1:0];
          st_nxt = S_SCMP;
        end else begin
          // compare against earlier midpoints of this item that were new
          for (int k = 0; k < 2; k++)
            if (!hit && 2'(k) < idx_r && pv_r[k] == pv_r[idx_r] &&
                (VW+1)'(mid_r[k]) >= vcnt_r) begin
              hit = 1'b1; mid_nxt[idx_r] = mid_r[k];
            end
          if (!hit) begin
            newi = vcnt_r + (VW+1)'(pend_r);
            mid_nxt[idx_r] = newi[11:0];
            pend_nxt = pend_r + 1'b1;
          end
          j_nxt = '0;
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 2'd2) st_nxt = S_MOVE;
        end
      end
      S_SCMP: begin
        if (vrd_r == pv_r[idx_r]) begin
          mid_nxt[idx_r] = j_r[11:0];
          j_nxt = '0;
          idx_nxt = idx_r + 1'b1;
          st_nxt = (idx_r == 2'd2) ? S_MOVE : S_SRD;
        end else begin
          j_nxt = j_r + 1'b1;
          st_nxt = S_SRD;
        end
      end
      S_MOVE: begin
        if (vcnt_r + (VW+1)'(pend_r) > (VW+1)'(VertexDepth)) begin
          opush = 1'b1; od = mk('0, '0, '0, '0, ST_VFULL, 1'b1);
          st_nxt = S_IDLE;
        end else begin
          taddr = c_r.face_index[TW-1:0]; twe = 1'b1; twd = moved_r;
          tcnt_nxt = tcnt_r - 1'b1;
          idx_nxt = 2'd0; emit_nxt = 3'd0;
          st_nxt = S_EMIT;
        end
      end
      default: begin
        // S_EMIT: write new vertices first, then four triangles
        if (idx_r < pend_r) begin
          vaddr = VW'(vcnt_r + (VW+1)'(idx_r));
          vwe = 1'b1;
          vwd = pv_r[0];
          for (int k = 0; k < 3; k++)
            if ((VW+1)'(mid_r[k]) == vcnt_r + (VW+1)'(idx_r)) vwd = pv_r[k];
          idx_nxt = idx_r + 1'b1;
        end else begin
          slot = tcnt_r + (TW+1)'(emit_r);
          unique case (emit_r)
            3'd0: twd = {mid_r[0], mid_r[1], mid_r[2]};
            3'd1: twd = {cor_r[0], mid_r[0], mid_r[2]};
            3'd2: twd = {mid_r[0], cor_r[1], mid_r[1]};
            default: twd = {mid_r[1], cor_r[2], mid_r[2]};
          endcase
          taddr = slot[TW-1:0]; twe = 1'b1;
          opush = 1'b1;
          od = mk(13'(slot), twd[35:24], twd[23:12], twd[11:0], ST_OK,
                  emit_r == 3'd3);
          emit_nxt = emit_r + 1'b1;
          if (emit_r == 3'd3) begin
            vcnt_nxt = vcnt_r + (VW+1)'(pend_r);
            tcnt_nxt = tcnt_r + (TW+1)'(4);
            st_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vcnt_r <= '0; tcnt_r <= '0;
    end else begin
      st_r <= st_nxt; vcnt_r <= vcnt_nxt; tcnt_r <= tcnt_nxt;
    end
    c_r <= c_nxt; cor_r <= cor_nxt; pv_r <= pv_nxt; mid_r <= mid_nxt;
    idx_r <= idx_nxt; pend_r <= pend_nxt; j_r <= j_nxt;
    moved_r <= moved_nxt; emit_r <= emit_nxt;
  end

  // result queue
  always_ff @(posedge clk) begin
    if (opush) oq_r[owp_r] <= od;
    if (!rst_n) begin
      owp_r <= '0; orp_r <= '0; ocnt_r <= '0;
    end else begin
      if (opush) owp_r <= owp_r + 1'b1;
      if (pop && !empty) orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + 3'(opush) - 3'(pop && !empty);
    end
  end
endmodule

[rtl/triangle_midpoint_subdivider.sv]
// Top level of the triangle midpoint subdivider.
//  channel | handshake        | payload
//  input   | in_push / in_full | in_data (in_beat_t)
//  result  | out_pop / out_empty | out_data (out_beat_t)
// Appends and clear are done in the idle state; a subdivide runs a linear
// search for each midpoint over the single vertex memory port.
// A new command starts only once the result queue has drained.
// Reset is synchronous and empties both stores' counts; no clearing pass.
`timescale 1ns / 1ps
module triangle_midpoint_subdivider import tms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_beat_t  in_data,
  output logic      out_empty,
  input  logic      out_pop,
  output out_beat_t out_data
);
  logic     cmd_valid, cmd_take;
  in_beat_t cmd;

  tms_front u_front (
    .clk, .rst_n, .push(in_push), .in_data, .full(in_full),
    .cmd_valid, .cmd, .cmd_take
  );

  tms_engine u_engine (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
    .empty(out_empty), .out_data, .pop(out_pop)
  );
endmodule

[rtl/tms_checker.sv]
// Port checker for the subdivider, bound to the top level.
`timescale 1ns / 1ps
module tms_checker import tms_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result beat changed while stalled");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status != ST_OK) |-> out_data.last)
    else $error("error beat without last");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.status != ST_OK) |-> (out_data.result_index == '0))
    else $error("error beat with non-zero index");
  a_rst: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("not empty after reset");
endmodule

bind triangle_midpoint_subdivider tms_checker u_chk (
  .clk, .rst_n, .in_full, .out_empty, .out_pop, .out_data
);
